[src/mcfs_pkg.sv]
`timescale 1ns / 1ps
package mcfs_pkg;
  localparam int MAX_CAMERAS_DEF   = 8;
  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int TIME_WIDTH_DEF    = 48;
  localparam int OUT_TIME_W        = 48;
  localparam int TAG_W             = 16;
  localparam int WIN_W             = 16;
  localparam int ACT_W             = 4;
  localparam int WEIGHT_W          = 17;
  localparam logic [3:0]  ACT_RESET = 4'd4;
  localparam logic [15:0] WIN_RESET = 16'd50;
  localparam logic [0:0]  REG_ACTIVE = 1'b0;
  localparam logic [0:0]  REG_WINDOW = 1'b1;
  localparam logic [1:0]  PICK_NEWEST = 2'd0;
  localparam logic [1:0]  PICK_OLDEST = 2'd1;
  localparam logic [1:0]  PICK_BLEND  = 2'd2;
  localparam logic        REQ_ARRIVAL = 1'b0;
  localparam logic        REQ_SYNC    = 1'b1;
endpackage

[src/multi_camera_frame_sync_selector.sv]
`timescale 1ns / 1ps
// input: a beat reaches the back through the two-entry queue; arrivals are stored when the back
// takes them, one per cycle while the back is idle and no result waits
// request: a status result if any active camera holds fewer than two frames, else a reference
// read, then per camera a history scan, a decision, a fetch when needed, a 16-bit blend weight
// division and an emit that result-side stalls hold; one request worked at a time
// reset (rst_n, synchronous): fill counts and pointers cleared, registers 4 and 50
module multi_camera_frame_sync_selector #(
  parameter int MAX_CAMERAS   = mcfs_pkg::MAX_CAMERAS_DEF,
  parameter int HISTORY_DEPTH = mcfs_pkg::HISTORY_DEPTH_DEF,
  parameter int TIME_WIDTH    = mcfs_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [2:0]  in_camera_index,
  input  logic [47:0] in_arrival_time_us,
  input  logic [15:0] in_frame_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [2:0]  out_out_camera,
  output logic [1:0]  out_pick_mode,
  output logic [15:0] out_first_tag,
  output logic [15:0] out_second_tag,
  output logic [16:0] out_blend_weight,
  output logic [47:0] out_out_time_us,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int QW = 1 + 3 + TIME_WIDTH + 16;
  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0] fq_data, bq_data;
  logic [3:0]    act;
  logic [15:0]   win;

  assign cfg_pready = 1'b1;

  mcfs_front #(.TIME_WIDTH(TIME_WIDTH), .QW(QW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_camera_index,
    .in_arrival_time_us, .in_frame_tag,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data),
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .active_cameras(act), .sync_window_ms(win)
  );

  mcfs_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  mcfs_back #(.MAX_CAMERAS(MAX_CAMERAS), .HISTORY_DEPTH(HISTORY_DEPTH),
              .TIME_WIDTH(TIME_WIDTH), .QW(QW)) u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .active_cameras(act), .sync_window_ms(win),
    .out_valid, .out_ready, .out_status, .out_out_camera, .out_pick_mode,
    .out_first_tag, .out_second_tag, .out_blend_weight, .out_out_time_us,
    .out_last
  );
endmodule

[src/mcfs_queue.sv]
`timescale 1ns / 1ps
// two-entry queue between front and back
module mcfs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !do_rd)
    else $error("read from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not grow");
endmodule

[src/mcfs_back.sv]
`timescale 1ns / 1ps
// sequencer: stores arrivals, walks histories on requests, divides bit-serially
module mcfs_back #(
  parameter int MAX_CAMERAS   = mcfs_pkg::MAX_CAMERAS_DEF,
  parameter int HISTORY_DEPTH = mcfs_pkg::HISTORY_DEPTH_DEF,
  parameter int TIME_WIDTH    = mcfs_pkg::TIME_WIDTH_DEF,
  parameter int QW            = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic [QW-1:0]                  q_data,
  input  logic [mcfs_pkg::ACT_W-1:0]     active_cameras,
  input  logic [mcfs_pkg::WIN_W-1:0]     sync_window_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic [2:0]                     out_out_camera,
  output logic [1:0]                     out_pick_mode,
  output logic [mcfs_pkg::TAG_W-1:0]     out_first_tag,
  output logic [mcfs_pkg::TAG_W-1:0]     out_second_tag,
  output logic [mcfs_pkg::WEIGHT_W-1:0]  out_blend_weight,
  output logic [mcfs_pkg::OUT_TIME_W-1:0] out_out_time_us,
  output logic                           out_last
);
  localparam int DEPTH  = MAX_CAMERAS * HISTORY_DEPTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW     = $clog2(HISTORY_DEPTH);
  localparam int FW     = $clog2(HISTORY_DEPTH + 1);
  localparam int CW     = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int NW     = $clog2(MAX_CAMERAS + 1);
  localparam int TW     = TIME_WIDTH;
  localparam logic [26:0] US_PER_MS = 27'd1000;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_REFRD = 11'b00000000100,
    S_REFWT = 11'b00000001000,
    S_SCAN  = 11'b00000010000,
    S_SCWT  = 11'b00000100000,
    S_DECIDE= 11'b00001000000,
    S_FETCH = 11'b00010000000,
    S_FWAIT = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TW-1:0]               time_mem [DEPTH];
  logic [mcfs_pkg::TAG_W-1:0]  tag_mem  [DEPTH];
  logic [TW-1:0]               rd_time_r;
  logic [mcfs_pkg::TAG_W-1:0]  rd_tag_r;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;

  logic [FW-1:0] fill_r [MAX_CAMERAS];
  logic [HW-1:0] oldp_r [MAX_CAMERAS];

  // decoded queue beat
  logic                       q_req;
  logic [2:0]                 q_cam;
  logic [TW-1:0]              q_time;
  logic [mcfs_pkg::TAG_W-1:0] q_tag;
  assign {q_req, q_cam, q_time, q_tag} = q_data;

  logic [NW-1:0] n_r;
  logic [CW-1:0] cam_r;
  logic [FW-1:0] k_r;
  logic [TW-1:0] ref_r, tn_r, dif_r;
  logic [mcfs_pkg::TAG_W-1:0] tagn_r, tagp_r;
  logic          found_r;
  logic [1:0]    pick_r;
  logic [4:0]    bit_r;
  logic [TW:0]   rem_r;
  logic [15:0]   frac_r;

  // result register
  logic                           ov_r;
  logic                           st_r, last_r;
  logic [2:0]                     oc_r;
  logic [1:0]                     pm_r;
  logic [mcfs_pkg::TAG_W-1:0]     t1_r, t2_r;
  logic [mcfs_pkg::WEIGHT_W-1:0]  bw_r;
  logic [mcfs_pkg::OUT_TIME_W-1:0] ot_r;

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_out_camera   = oc_r;
  assign out_pick_mode    = pm_r;
  assign out_first_tag    = t1_r;
  assign out_second_tag   = t2_r;
  assign out_blend_weight = bw_r;
  assign out_out_time_us  = ot_r;
  assign out_last         = last_r;

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] c,
                                         input logic [HW-1:0] op,
                                         input logic [FW-1:0] k);
    logic [HW+FW:0] s;
    s = (HW+FW+1)'(op) + (HW+FW+1)'(k);
    if (s >= (HW+FW+1)'(HISTORY_DEPTH)) s = s - (HW+FW+1)'(HISTORY_DEPTH);
    return AW'(c * HISTORY_DEPTH) + AW'(s);
  endfunction

  logic [NW-1:0] n_eff;
  always_comb begin
    if (active_cameras == '0) n_eff = NW'(1);
    else if (32'(active_cameras) > MAX_CAMERAS) n_eff = NW'(MAX_CAMERAS);
    else n_eff = NW'(active_cameras);
  end

  logic          any_short;
  always_comb begin
    any_short = 1'b0;
    for (int i = 0; i < MAX_CAMERAS; i++)
      if (i < 32'(n_r) && fill_r[i] < FW'(2)) any_short = 1'b1;
  end

  logic [CW-1:0] refcam;
  assign refcam = CW'(n_eff >> 1);

  logic arr_ok;
  assign arr_ok = (32'(q_cam) < MAX_CAMERAS);
  logic [CW-1:0] qc;
  assign qc = CW'(q_cam);

  assign q_ready = (state_r == S_IDLE) && !ov_r;
  assign wr_en   = (state_r == S_IDLE) && q_valid && !ov_r && !q_req && arr_ok;
  assign wr_addr = slot(qc, oldp_r[qc],
                        (fill_r[qc] < FW'(HISTORY_DEPTH)) ? fill_r[qc] : FW'(0));

  // read address from the current camera and history index
  logic [FW-1:0] cnt_c;
  assign cnt_c = fill_r[cam_r];
  always_comb begin
    rd_addr = slot(cam_r, oldp_r[cam_r], k_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= q_time;
      tag_mem[wr_addr]  <= q_tag;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_tag_r  <= tag_mem[rd_addr];
  end

  logic [TW:0] rem_fr, sub_fr;
  assign rem_fr = {rem_r[TW-1:0], 1'b0};
  assign sub_fr = rem_fr - {1'b0, dif_r};

  // floor(gap / 1000) > window  is the same as  gap >= (window + 1) * 1000
  logic [26:0] win_lim;
  assign win_lim = (27'(sync_window_ms) + 27'd1) * US_PER_MS;
  logic too_far;
  assign too_far = dif_r >= TW'(win_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAX_CAMERAS; i++) begin
        fill_r[i] <= '0;
        oldp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (wr_en) begin
        if (fill_r[qc] < FW'(HISTORY_DEPTH)) fill_r[qc] <= fill_r[qc] + FW'(1);
        else if (oldp_r[qc] == HW'(HISTORY_DEPTH - 1)) oldp_r[qc] <= '0;
        else oldp_r[qc] <= oldp_r[qc] + HW'(1);
      end
      if (state_r == S_CHECK && any_short) ov_r <= 1'b1;
      if (state_r == S_EMIT && !ov_r) ov_r <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (q_valid && !ov_r && q_req) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = any_short ? S_IDLE : S_REFRD;
      S_REFRD:  state_nxt = S_REFWT;
      S_REFWT:  state_nxt = S_SCAN;
      S_SCAN:   state_nxt = S_SCWT;
      S_SCWT: begin
        if (rd_time_r > ref_r) state_nxt = S_DECIDE;
        else if (k_r + FW'(1) == cnt_c) state_nxt = S_DECIDE;
        else state_nxt = S_SCAN;
      end
      S_DECIDE: begin
        if (found_r && (too_far || k_r != '0)) state_nxt = S_FETCH;
        else state_nxt = S_EMIT;
      end
      S_FETCH:  state_nxt = S_FWAIT;
      S_FWAIT:  state_nxt = (pick_r == mcfs_pkg::PICK_BLEND) ? S_DIV : S_EMIT;
      S_DIV:    if (bit_r == 5'd1) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!ov_r) state_nxt = (NW'(cam_r) + NW'(1) == n_r) ? S_IDLE : S_SCAN;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r   <= n_eff;
        cam_r <= refcam;
        k_r   <= fill_r[refcam] - FW'(1);
      end
      S_CHECK: begin
        if (any_short) begin
          st_r <= 1'b1; oc_r <= '0; pm_r <= mcfs_pkg::PICK_NEWEST; t1_r <= '0; t2_r <= '0;
          bw_r <= '0; ot_r <= '0; last_r <= 1'b1;
        end
      end
      S_REFRD: ;
      S_REFWT: begin
        ref_r <= rd_time_r;
        cam_r <= '0;
        k_r   <= '0;
      end
      S_SCAN: ;
      S_SCWT: begin
        // newest sits at k_r when nothing later was found
        tn_r    <= rd_time_r;
        tagn_r  <= rd_tag_r;
        found_r <= rd_time_r > ref_r;
        if (!(rd_time_r > ref_r) && (k_r + FW'(1) != cnt_c)) k_r <= k_r + FW'(1);
        dif_r   <= rd_time_r - ref_r;
      end
      S_DECIDE: begin
        if (!found_r || too_far) pick_r <= mcfs_pkg::PICK_NEWEST;
        else if (k_r == '0) pick_r <= mcfs_pkg::PICK_OLDEST;
        else pick_r <= mcfs_pkg::PICK_BLEND;
        if (found_r && too_far) k_r <= cnt_c - FW'(1);
        else if (found_r && k_r != '0) k_r <= k_r - FW'(1);
      end
      S_FETCH: ;
      S_FWAIT: begin
        if (pick_r == mcfs_pkg::PICK_BLEND) begin
          tagp_r <= rd_tag_r;
          dif_r  <= tn_r - rd_time_r;
          rem_r  <= {1'b0, ref_r - rd_time_r};
          bit_r  <= 5'd16;
        end else begin
          tn_r   <= rd_time_r;
          tagn_r <= rd_tag_r;
        end
      end
      S_DIV: begin
        bit_r <= bit_r - 5'd1;
        if (!sub_fr[TW]) begin
          rem_r  <= sub_fr;
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          rem_r  <= rem_fr;
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      S_EMIT: begin
        if (!ov_r) begin
          st_r   <= 1'b0;
          oc_r   <= 3'(cam_r);
          pm_r   <= pick_r;
          last_r <= (NW'(cam_r) + NW'(1) == n_r);
          if (pick_r == mcfs_pkg::PICK_BLEND) begin
            t1_r <= tagp_r; t2_r <= tagn_r;
            bw_r <= {1'b0, frac_r};
            ot_r <= mcfs_pkg::OUT_TIME_W'(ref_r);
          end else begin
            t1_r <= tagn_r; t2_r <= '0;
            bw_r <= '0;
            ot_r <= mcfs_pkg::OUT_TIME_W'(tn_r);
          end
          cam_r <= cam_r + CW'(1);
          k_r   <= '0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_ready)
    else $error("queue drained while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dif_r != '0))
    else $error("zero divisor");
endmodule

[src/mcfs_front.sv]
`timescale 1ns / 1ps
// input side: takes beats, packs them, holds config registers
module mcfs_front #(
  parameter int TIME_WIDTH = mcfs_pkg::TIME_WIDTH_DEF,
  parameter int QW         = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [2:0]                  in_camera_index,
  input  logic [47:0]                 in_arrival_time_us,
  input  logic [15:0]                 in_frame_tag,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [QW-1:0]               q_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic [mcfs_pkg::ACT_W-1:0]  active_cameras,
  output logic [mcfs_pkg::WIN_W-1:0]  sync_window_ms
);
  logic [mcfs_pkg::ACT_W-1:0] act_r;
  logic [mcfs_pkg::WIN_W-1:0] win_r;
  logic [TIME_WIDTH-1:0]      t;

  always_comb begin
    t = '0;
    for (int i = 0; i < TIME_WIDTH; i++) if (i < 48) t[i] = in_arrival_time_us[i];
  end

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign q_data   = {in_req_type, in_camera_index, t, in_frame_tag};
  assign active_cameras = act_r;
  assign sync_window_ms = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= mcfs_pkg::ACT_RESET;
      win_r <= mcfs_pkg::WIN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mcfs_pkg::REG_ACTIVE) act_r <= pwdata[3:0];
      else win_r <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == mcfs_pkg::REG_ACTIVE) prdata = {28'd0, act_r};
    else prdata = {16'd0, win_r};
  end
endmodule
